/* hdl/ica_pkg.sv */
// Inode cache acquire: shared types, widths and constants.
// No dependencies; imported by ica_ctrl, ica_dp, the top level and the testbench.
`default_nettype none
package ica_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 64;

  localparam int unsigned DEV_W   = 8;
  localparam int unsigned INO_W   = 16;
  localparam int unsigned REF_W   = 8;
  localparam int unsigned BLK_W   = 24;
  localparam int unsigned OFS_W   = 3;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned ENTRY_W = DEV_W + INO_W + REF_W;

  localparam int unsigned IN_DATA_W   = 24;
  localparam int unsigned OUT_DATA_W  = 48;
  localparam int unsigned OUT_USER_W  = 3;

  localparam logic [REF_W-1:0] REF_MAX = {REF_W{1'b1}};
  localparam logic [REF_W-1:0] REF_ONE = REF_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_RESULT
  } ica_state_e;

  typedef struct packed {
    logic accept;
    logic scan;
    logic commit;
    logic load;
  } ica_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_busy;
  } ica_sts_t;

  function automatic logic [REF_W-1:0] ref_inc(input logic [REF_W-1:0] r);
    ref_inc = (r == REF_MAX) ? REF_MAX : r + REF_ONE;
  endfunction

endpackage
`default_nettype wire

/* hdl/ica_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ica_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* hdl/ica_ctrl.sv */
// Sequencer for the inode cache acquire: idle, table scan, commit, result.
// Depends on ica_pkg.
`default_nettype none
module ica_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire ica_pkg::ica_sts_t sts_i,
  output ica_pkg::ica_cmd_t      cmd_o
);
  import ica_pkg::*;

  ica_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_RESULT;
      end
      ST_RESULT: begin
        if (!sts_i.out_busy) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
    endcase
  end

endmodule
`default_nettype wire

/* hdl/ica_dp.sv */
// Datapath: slot RAM with valid bits, scan pipeline, first-hit and first-free
// trackers, write-back and result register. Depends on ica_pkg and ica_ram.
`default_nettype none
module ica_dp #(
  parameter int unsigned TABLE_ENTRIES = ica_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire ica_pkg::ica_cmd_t                   cmd_i,
  output ica_pkg::ica_sts_t                        sts_o,
  input  wire logic [ica_pkg::IN_DATA_W-1:0]       req_data_i,
  input  wire logic [ica_pkg::BLK_W-1:0]           start_block_i,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic      [ica_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  output logic      [ica_pkg::OUT_USER_W-1:0]      m_axis_tuser
);
  import ica_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);

  logic [DEV_W-1:0]         dev_q;
  logic [INO_W-1:0]         ino_q;
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [AW-1:0]            scan_addr_q;
  logic                     issue_done_q;
  logic                     cmp_vld_q;
  logic [AW-1:0]            cmp_addr_q;
  logic                     rd_valid_q;
  logic                     hit_q, free_q;
  logic [AW-1:0]            hit_idx_q, free_idx_q;
  logic [REF_W-1:0]         hit_refs_q;
  logic                     m_valid_q;

  logic                     rd_en;
  logic [ENTRY_W-1:0]       rdata;
  logic [DEV_W-1:0]         e_dev;
  logic [INO_W-1:0]         e_ino;
  logic [REF_W-1:0]         e_refs;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic [ENTRY_W-1:0]       wr_data;
  logic [INO_W-1:0]         ino_m1;
  logic [BLK_W-1:0]         blk;
  logic [AW-1:0]            res_idx;
  logic [REF_W-1:0]         res_refs;
  logic                     claimed;
  logic                     full;

  assign rd_en = cmd_i.scan && !issue_done_q;

  ica_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (scan_addr_q),
    .rdata_o (rdata)
  );

  // never-written slots read as zero
  assign e_dev  = rd_valid_q ? rdata[DEV_W-1:0] : '0;
  assign e_ino  = rd_valid_q ? rdata[DEV_W +: INO_W] : '0;
  assign e_refs = rd_valid_q ? rdata[DEV_W+INO_W +: REF_W] : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      dev_q <= req_data_i[DEV_W-1:0];
      ino_q <= req_data_i[DEV_W +: INO_W];
    end
    if (rd_en) begin
      cmp_addr_q <= scan_addr_q;
      rd_valid_q <= valid_q[scan_addr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_addr_q  <= '0;
      issue_done_q <= 1'b0;
      cmp_vld_q    <= 1'b0;
      hit_q        <= 1'b0;
      free_q       <= 1'b0;
      hit_idx_q    <= '0;
      free_idx_q   <= '0;
      hit_refs_q   <= '0;
    end else if (cmd_i.accept) begin
      scan_addr_q  <= '0;
      issue_done_q <= 1'b0;
      cmp_vld_q    <= 1'b0;
      hit_q        <= 1'b0;
      free_q       <= 1'b0;
    end else begin
      cmp_vld_q <= rd_en;
      if (rd_en) begin
        if (scan_addr_q == LAST_ADDR) begin
          issue_done_q <= 1'b1;
        end else begin
          scan_addr_q <= scan_addr_q + AW'(1);
        end
      end
      if (cmp_vld_q) begin
        if (!hit_q && e_dev == dev_q && e_ino == ino_q) begin
          hit_q      <= 1'b1;
          hit_idx_q  <= cmp_addr_q;
          hit_refs_q <= e_refs;
        end
        if (!free_q && e_refs == '0) begin
          free_q     <= 1'b1;
          free_idx_q <= cmp_addr_q;
        end
      end
    end
  end

  assign sts_o.scan_done = issue_done_q && !cmp_vld_q;
  assign sts_o.out_busy  = m_valid_q && !m_axis_tready;

  // write-back
  assign claimed  = !hit_q && free_q;
  assign full     = !hit_q && !free_q;
  assign res_idx  = hit_q ? hit_idx_q : (free_q ? free_idx_q : '0);
  assign res_refs = hit_q ? ref_inc(hit_refs_q) : (free_q ? REF_ONE : '0);
  assign wr_en    = cmd_i.commit && !full;
  assign wr_addr  = res_idx;
  assign wr_data  = {res_refs, ino_q, dev_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[wr_addr] <= 1'b1;
    end
  end

  assign ino_m1 = ino_q - INO_W'(1);
  assign blk    = start_block_i + BLK_W'(ino_m1[INO_W-1:OFS_W]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      m_axis_tdata <= {7'b0, res_refs,
                       claimed ? ino_m1[OFS_W-1:0] : OFS_W'(0),
                       claimed ? blk : BLK_W'(0),
                       SLOT_W'(res_idx)};
      m_axis_tuser <= {full, claimed, hit_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;

endmodule
`default_nettype wire

/* hdl/inode_cache_acquire.sv */
// Channel   Dir  Handshake                      Payload
// request   in   s_axis_tvalid/s_axis_tready    s_axis_tdata: device_id, inode_number
// result    out  m_axis_tvalid/m_axis_tready    m_axis_tdata, m_axis_tuser (flags)
// config    in   cfg_we_i (no wait)             cfg_wdata_i: inode_table_start_block
//
// Each request makes a single pass over the slot RAM read port, which
// finds the first match and the first free slot together.
// Reset leaves all slots reading as empty through per-slot valid bits.
// A finished result waits in the output register; the next request is taken
// while it is held, but its result stalls until the register is free.
// Top level of the inode cache acquire block. Depends on ica_pkg, ica_ctrl, ica_dp.
`default_nettype none
module inode_cache_acquire #(
  parameter int unsigned TABLE_ENTRIES = ica_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [ica_pkg::BLK_W-1:0]      cfg_wdata_i,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // [7:0] device_id, [23:8] inode_number
  input  wire logic [ica_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [5:0] slot_index, [29:6] fetch_block, [32:30] block_offset,
  // [40:33] reference_count, [47:41] zero
  output logic      [ica_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // [0] was_resident, [1] newly_claimed, [2] table_full
  output logic      [ica_pkg::OUT_USER_W-1:0] m_axis_tuser
);
  import ica_pkg::*;

  logic [BLK_W-1:0] start_block_q;
  ica_cmd_t         cmd;
  ica_sts_t         sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_block_q <= '0;
    end else if (cfg_we_i) begin
      start_block_q <= cfg_wdata_i;
    end
  end

  ica_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  ica_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .req_data_i    (s_axis_tdata),
    .start_block_i (start_block_q),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  a_one_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot(m_axis_tuser))
    else $error("result must carry exactly one outcome flag");

  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[2]) |-> (m_axis_tdata[40:0] == '0))
    else $error("full result must carry zero fields");

  a_claim_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata[40:33] == REF_ONE))
    else $error("claimed slot must start at count one");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("sequencer must go busy after a transaction");

endmodule
`default_nettype wire

/* bench/tb_inode_cache_acquire.sv */
// Testbench for inode_cache_acquire: directed and random acquire requests,
// checked against an inline slot-table predictor. Depends on ica_pkg and inode_cache_acquire.
`timescale 1ns / 1ps
module tb_inode_cache_acquire;
  import ica_pkg::*;

  localparam int unsigned SLOTS = TABLE_ENTRIES_DEF;
  localparam int unsigned INODES_PER_BLOCK = 8;
  localparam int unsigned SETTLE_CYCLES = 2 * (SLOTS + 5);
  localparam int unsigned POOL_MAX = 96;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              resident;
    logic              claimed;
    logic              full;
    logic [BLK_W-1:0]  blk;
    logic [OFS_W-1:0]  ofs;
    logic [REF_W-1:0]  refs;
  } grant_t;

  class inode_slot_table;
    logic [DEV_W-1:0] slot_dev [SLOTS];
    logic [INO_W-1:0] slot_ino [SLOTS];
    logic [REF_W-1:0] slot_refs [SLOTS];
    logic [BLK_W-1:0] table_start;
    grant_t           expected_grants [$];
    int unsigned      mismatches;
    int unsigned      grants_seen;

    function new();
      int i;
      for (i = 0; i < SLOTS; i++) begin
        slot_dev[i]  = '0;
        slot_ino[i]  = '0;
        slot_refs[i] = '0;
      end
      table_start = '0;
      mismatches  = 0;
      grants_seen = 0;
    endfunction

    function void set_start(input logic [BLK_W-1:0] v);
      table_start = v;
    endfunction

    function void note_acquire(input logic [DEV_W-1:0] dev, input logic [INO_W-1:0] ino);
      grant_t g;
      int i;
      int hit;
      int spare;
      logic [INO_W-1:0] idx0;
      g = '0;
      hit = -1;
      spare = -1;
      for (i = 0; i < SLOTS; i++)
        if (hit < 0 && slot_dev[i] == dev && slot_ino[i] == ino) hit = i;
      if (hit >= 0) begin
        if (slot_refs[hit] != REF_MAX) slot_refs[hit] = slot_refs[hit] + 1'b1;
        g.slot     = SLOT_W'(hit);
        g.resident = 1'b1;
        g.refs     = slot_refs[hit];
      end else begin
        for (i = 0; i < SLOTS; i++)
          if (spare < 0 && slot_refs[i] == '0) spare = i;
        if (spare >= 0) begin
          idx0 = ino - 1'b1;
          slot_refs[spare] = 8'd1;
          slot_dev[spare]  = dev;
          slot_ino[spare]  = ino;
          g.slot    = SLOT_W'(spare);
          g.claimed = 1'b1;
          g.refs    = 8'd1;
          g.blk     = table_start + BLK_W'(idx0 / INODES_PER_BLOCK);
          g.ofs     = OFS_W'(idx0 % INODES_PER_BLOCK);
        end else begin
          g.full = 1'b1;
        end
      end
      expected_grants.push_back(g);
    endfunction

    task flag_mismatch(input string what);
      mismatches++;
      $display("[%0t] transaction %0d: %s", $realtime, grants_seen, what);
    endtask

    task compare_field(input string name, input logic [31:0] got,
                       input logic [31:0] want);
      if (got !== want) flag_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
    endtask

    task check_grant(input logic [OUT_DATA_W-1:0] data,
                     input logic [OUT_USER_W-1:0] user);
      grant_t want;
      grants_seen++;
      if (expected_grants.size() == 0) begin
        flag_mismatch("result with no request outstanding");
        return;
      end
      want = expected_grants.pop_front();
      compare_field("slot_index", 32'(data[5:0]), 32'(want.slot));
      compare_field("fetch_block", 32'(data[29:6]), 32'(want.blk));
      compare_field("block_offset", 32'(data[32:30]), 32'(want.ofs));
      compare_field("reference_count", 32'(data[40:33]), 32'(want.refs));
      compare_field("tdata padding", 32'(data[47:41]), 32'd0);
      compare_field("was_resident", 32'(user[0]), 32'(want.resident));
      compare_field("newly_claimed", 32'(user[1]), 32'(want.claimed));
      compare_field("table_full", 32'(user[2]), 32'(want.full));
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [BLK_W-1:0]      cfg_wdata_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;

  bit                    gaps_on = 1'b1;
  logic [23:0]           key_pool [$];
  inode_slot_table       slots;

  inode_cache_acquire u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= !(gaps_on && $urandom_range(0, 99) < 17);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) slots.check_grant(m_axis_tdata, m_axis_tuser);
  end

  task automatic send_request(input logic [DEV_W-1:0] dev, input logic [INO_W-1:0] ino);
    bit known;
    known = 1'b0;
    @(negedge clk_i);
    while (gaps_on && $urandom_range(0, 99) < 17) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ino, dev};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    slots.note_acquire(dev, ino);
    foreach (key_pool[k]) if (key_pool[k] == {ino, dev}) known = 1'b1;
    if (!known && key_pool.size() < POOL_MAX) key_pool.push_back({ino, dev});
  endtask

  // stop sending and let every outstanding grant come back
  task automatic drain_grants();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (slots.expected_grants.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_table_start(input logic [BLK_W-1:0] v);
    drain_grants();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    slots.set_start(v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_request();
    int unsigned r;
    logic [23:0] key;
    logic [DEV_W-1:0] dev;
    logic [INO_W-1:0] ino;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      key = key_pool[0];
      dev = key[7:0];
      ino = key[23:8];
    end else if (r < 35) begin
      dev = DEV_W'($urandom);
      ino = INO_W'($urandom);
    end else if (r < 40) begin
      case ($urandom_range(0, 2))
        0: dev = 8'h00;
        1: dev = 8'hFF;
        default: dev = DEV_W'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0: ino = 16'h0000;
        1: ino = 16'h0001;
        2: ino = 16'hFFF8;
        default: ino = 16'hFFFF;
      endcase
    end else begin
      key = key_pool[$urandom_range(0, key_pool.size() - 1)];
      dev = key[7:0];
      ino = key[23:8];
    end
    send_request(dev, ino);
  endtask

  initial begin
    int ph;
    logic [BLK_W-1:0] start_val;
    slots = new();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // slot 0 holds device 0 / inode 0 with count zero after reset
    send_request(8'h00, 16'h0000);
    send_request(8'h00, 16'h0000);
    send_request(8'hFF, 16'hFFFF);
    send_request(8'h00, 16'h0001);
    write_table_start(24'hFFFFFF);
    send_request(8'h01, 16'h0000);
    send_request(8'h01, 16'h0008);
    send_request(8'h01, 16'h0009);
    send_request(8'h80, 16'h8000);
    send_request(8'h55, 16'hAAAA);
    send_request(8'hAA, 16'h5555);
    send_request(8'hFF, 16'hFFFF);
    write_table_start(24'h000000);
    send_request(8'h01, 16'h0007);
    send_request(8'hFE, 16'hFFF8);
    send_request(8'h7F, 16'h0001);
    send_request(8'h01, 16'h0000);
    send_request(8'h00, 16'h0000);

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: start_val = 24'hFFF000;
        3: start_val = 24'h000001;
        5: start_val = 24'hFFFFFF;
        default: start_val = BLK_W'($urandom);
      endcase
      write_table_start(start_val);
      gaps_on = (ph != 2);
      repeat (305) random_request();
    end
    gaps_on = 1'b1;

    drain_grants();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (slots.mismatches == 0 && slots.expected_grants.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
